### hdl/session_table_rate_limiter_defines.svh
// Assertion macros used by the session table rate limiter datapath.
// Expects signals named clk and arst_n in the including module.
`ifndef SESSION_TABLE_RATE_LIMITER_DEFINES_SVH
`define SESSION_TABLE_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define STRL_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define STRL_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### hdl/strl_pkg.sv
// Shared types and constants for the session table rate limiter.
// No dependencies.
package strl_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;

	localparam logic [7:0] MSG_LIMIT_RESET = 8'd10;
	localparam logic [7:0] COUNT_MAX       = 8'd255;

	localparam int CONN_W  = 16;
	localparam int TIME_W  = 32;
	localparam int SLOT_W  = 5;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 8;

	// controller -> datapath
	typedef struct packed {
		logic load;      // input transfer, capture the item
		logic match_en;  // compare all slots
		logic enc_en;    // pick lowest slot, read its entry
		logic upd_en;    // write back and post the result
	} strl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;  // result register full and not being taken
	} strl_sts_t;

endpackage

### hdl/strl_ctrl.sv
// Sequencer for the session table rate limiter.
// Depends on strl_pkg.
module strl_ctrl import strl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  strl_sts_t sts,
	output strl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_ENC,
		ST_UPD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_MATCH;
				end
				ST_MATCH: state_q <= ST_ENC;
				ST_ENC:   state_q <= ST_UPD;
				ST_UPD: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready     = (state_q == ST_IDLE);
	assign cmd.load     = s_tready && s_tvalid;
	assign cmd.match_en = (state_q == ST_MATCH);
	assign cmd.enc_en   = (state_q == ST_ENC);
	assign cmd.upd_en   = (state_q == ST_UPD) && !sts.out_busy;

endmodule

### hdl/strl_dp.sv
// Datapath: slot table, count/window memories, limiter math, result register.
// Depends on strl_pkg and session_table_rate_limiter_defines.svh.
`include "session_table_rate_limiter_defines.svh"

module strl_dp import strl_pkg::*; #(
	parameter int NUM_SESSIONS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  strl_cmd_t               cmd,
	output strl_sts_t               sts,
	input  logic [1:0]              in_command,
	input  logic [CONN_W-1:0]       in_conn_id,
	input  logic [TIME_W-1:0]       in_now,
	input  logic                    msg_limit_we,
	input  logic [7:0]              msg_limit_wdata,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    res_found,
	output logic                    res_allowed,
	output logic [SLOT_W-1:0]       res_slot_index
);

	localparam int IDX_W = $clog2(NUM_SESSIONS);

	logic [7:0]              msg_limit_q;
	logic [1:0]              cmd_q;
	logic [CONN_W-1:0]       id_q;
	logic [TIME_W-1:0]       now_q;

	logic [NUM_SESSIONS-1:0] slot_valid_q;
	logic [CONN_W-1:0]       slot_conn_q [NUM_SESSIONS];
	logic [7:0]              count_mem   [NUM_SESSIONS];
	logic [TIME_W-1:0]       window_mem  [NUM_SESSIONS];

	logic [NUM_SESSIONS-1:0] match_q;
	logic [NUM_SESSIONS-1:0] free_q;
	logic [NUM_SESSIONS-1:0] pick_vec;
	logic [IDX_W-1:0]        pick_idx;
	logic                    pick_hit;
	logic [IDX_W-1:0]        idx_q;
	logic                    hit_q;
	logic [7:0]              rd_count_q;
	logic [TIME_W-1:0]       rd_window_q;

	logic [8:0]              cap;
	logic [8:0]              cnt_base;
	logic [8:0]              cnt_next;
	logic                    over;
	logic                    mem_we;
	logic [7:0]              count_wdata;
	logic                    allowed_d;

	logic                    res_valid_q;
	logic                    found_q;
	logic                    allowed_q;
	logic [IDX_W-1:0]        res_idx_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_limit_q <= MSG_LIMIT_RESET;
		end else if (msg_limit_we) begin
			msg_limit_q <= msg_limit_wdata;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			id_q  <= in_conn_id;
			now_q <= in_now;
		end
	end

	// parallel compare over all slots
	always_ff @(posedge clk) begin
		if (cmd.match_en) begin
			for (int i = 0; i < NUM_SESSIONS; i++) begin
				match_q[i] <= slot_valid_q[i] && (slot_conn_q[i] == id_q);
				free_q[i]  <= !slot_valid_q[i];
			end
		end
	end

	// lowest set bit wins
	always_comb begin
		pick_vec = (cmd_q == CMD_ADD) ? free_q : match_q;
		pick_idx = '0;
		for (int i = NUM_SESSIONS - 1; i >= 0; i--) begin
			if (pick_vec[i]) pick_idx = IDX_W'(i);
		end
		pick_hit = (|pick_vec) &&
			(cmd_q == CMD_ADD || cmd_q == CMD_REMOVE || cmd_q == CMD_CHECK);
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_en) begin
			idx_q       <= pick_idx;
			hit_q       <= pick_hit;
			rd_count_q  <= count_mem[pick_idx];
			rd_window_q <= window_mem[pick_idx];
		end
	end

	// limiter: new window restarts the count, saturate at limit+1 (max 255)
	always_comb begin
		cap      = (msg_limit_q == COUNT_MAX) ? {1'b0, COUNT_MAX}
			: {1'b0, msg_limit_q} + 9'd1;
		cnt_base = (rd_window_q != now_q) ? 9'd0 : {1'b0, rd_count_q};
		cnt_next = (cnt_base >= cap) ? cap : cnt_base + 9'd1;
		over     = cnt_next > {1'b0, msg_limit_q};
	end

	always_comb begin
		mem_we      = 1'b0;
		count_wdata = cnt_next[7:0];
		allowed_d   = hit_q;
		unique case (cmd_q)
			CMD_ADD: begin
				mem_we      = cmd.upd_en && hit_q;
				count_wdata = '0;
			end
			CMD_CHECK: begin
				mem_we    = cmd.upd_en && hit_q;
				allowed_d = hit_q && !over;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// window is always the current second after add or check
	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[idx_q]  <= count_wdata;
			window_mem[idx_q] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.upd_en && hit_q) begin
			if (cmd_q == CMD_ADD) slot_valid_q[idx_q] <= 1'b1;
			else if (cmd_q == CMD_REMOVE) slot_valid_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en && hit_q && cmd_q == CMD_ADD) begin
			slot_conn_q[idx_q] <= id_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.upd_en) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			found_q   <= hit_q;
			allowed_q <= allowed_d;
			res_idx_q <= hit_q ? idx_q : '0;
		end
	end

	assign sts.out_busy   = res_valid_q && !res_ready;
	assign res_valid      = res_valid_q;
	assign res_found      = found_q;
	assign res_allowed    = allowed_q;
	assign res_slot_index = SLOT_W'(res_idx_q);

	`STRL_ASSERT_NEXT(a_add_sets_valid, cmd.upd_en && hit_q && cmd_q == CMD_ADD,
		slot_valid_q[idx_q], "add did not mark slot valid")
	`STRL_ASSERT_NEXT(a_remove_clears_valid, cmd.upd_en && hit_q && cmd_q == CMD_REMOVE,
		!slot_valid_q[idx_q], "remove did not free slot")
	`STRL_ASSERT_IMPL(a_allowed_needs_found, res_valid_q,
		found_q || !allowed_q, "allowed without found")
	`STRL_ASSERT_IMPL(a_count_bounded, mem_we && cmd_q == CMD_CHECK,
		cnt_next <= cap, "count above saturation bound")

endmodule

### hdl/session_table_rate_limiter.sv
// Top level of the session table rate limiter: sequencer plus datapath.
// Depends on strl_pkg, strl_ctrl and strl_dp.
//
// Usage: commands arrive on the s_ stream (tuser = command, tdata = conn_id and
// now_seconds); one result per command leaves on the m_ stream (found, allowed,
// slot_index). The message limit is written with msg_limit_we/msg_limit_wdata while idle.
// Each command runs compare, lowest-slot encode with count/window read, then
// write-back, each step registered; a new command is taken only once the previous
// one has left write-back. These steps hold the slot compare, the priority encoder
// feeding the entry memories and the read-modify-write of one entry.
// The result sits in an output register; while m_tready is low the next command is
// still accepted and worked up to write-back, where it waits for the register to free.
// Reset frees every slot and loads the message limit with 10; no clearing pass is needed.
module session_table_rate_limiter import strl_pkg::*; #(
	parameter int NUM_SESSIONS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] conn_id, [47:16] now_seconds
	input  logic [1:0]             s_tuser,   // [1:0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [1] allowed, [6:2] slot_index
	input  logic                   msg_limit_we,
	input  logic [7:0]             msg_limit_wdata
);

	strl_cmd_t          cmd;
	strl_sts_t          sts;
	logic               found;
	logic               allowed;
	logic [SLOT_W-1:0]  slot_index;

	strl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	strl_dp #(
		.NUM_SESSIONS (NUM_SESSIONS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_command      (s_tuser),
		.in_conn_id      (s_tdata[CONN_W-1:0]),
		.in_now          (s_tdata[CONN_W+TIME_W-1:CONN_W]),
		.msg_limit_we    (msg_limit_we),
		.msg_limit_wdata (msg_limit_wdata),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res_found       (found),
		.res_allowed     (allowed),
		.res_slot_index  (slot_index)
	);

	assign m_tdata = {1'b0, slot_index, allowed, found};

endmodule

### test/session_table_rate_limiter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for session_table_rate_limiter: directed rows, then random phases.
// Depends on strl_pkg and the RTL top level; results are checked by an in-bench table model.

module session_table_rate_limiter_tb;
	import strl_pkg::*;

	localparam int SLOTS = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic              found;
		logic              allowed;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	typedef struct packed {
		logic        limit_row;  // row writes the message limit instead of sending a command
		logic [7:0]  limit;
		logic [1:0]  cmd;
		logic [15:0] id;
		logic [31:0] now;
		logic        typed;      // want holds a hand-written result
		verdict_t    want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [15:0] conn_id, [47:16] now_seconds
	logic [1:0]             s_tuser = '0;   // [1:0] command
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // [0] found, [1] allowed, [6:2] slot_index
	logic                   msg_limit_we = 1'b0;
	logic [7:0]             msg_limit_wdata = '0;

	session_table_rate_limiter #(.NUM_SESSIONS(SLOTS)) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.msg_limit_we    (msg_limit_we),
		.msg_limit_wdata (msg_limit_wdata)
	);

	always #10 clk = ~clk;

	// session table model
	logic        sess_valid  [SLOTS];
	logic [15:0] sess_conn   [SLOTS];
	logic [7:0]  sess_count  [SLOTS];
	logic [31:0] sess_window [SLOTS];
	logic [7:0]  limit_now;

	verdict_t  pending_verdicts[$];
	stim_row_t directed_rows[$];
	logic [15:0] id_pool [12];
	logic [15:0] last_id;
	logic [31:0] clock_sec;

	int  mismatch_count = 0;
	int  results_seen = 0;
	int  n_add = 0, n_remove = 0, n_check = 0, n_unused = 0;
	int  n_over = 0, n_full = 0;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	function automatic int lowest_slot(input bit want_free, input logic [15:0] id);
		int i;
		int s;
		s = -1;
		for (i = 0; i < SLOTS; i++) begin
			if (s < 0) begin
				if (want_free && !sess_valid[i])
					s = i;
				else if (!want_free && sess_valid[i] && sess_conn[i] == id)
					s = i;
			end
		end
		return s;
	endfunction

	// applies one command to the session table and returns its result
	function automatic verdict_t apply_command(input logic [1:0] cmd, input logic [15:0] id,
			input logic [31:0] now);
		verdict_t v;
		int s;
		int unsigned cap;
		int unsigned cnt;
		v = '0;
		case (cmd)
			CMD_ADD: begin
				s = lowest_slot(1'b1, id);
				if (s >= 0) begin
					sess_valid[s] = 1'b1;
					sess_conn[s] = id;
					sess_count[s] = '0;
					sess_window[s] = now;
					v = '{found: 1'b1, allowed: 1'b1, slot: s[SLOT_W-1:0]};
				end
			end
			CMD_REMOVE: begin
				s = lowest_slot(1'b0, id);
				if (s >= 0) begin
					sess_valid[s] = 1'b0;
					v = '{found: 1'b1, allowed: 1'b1, slot: s[SLOT_W-1:0]};
				end
			end
			CMD_CHECK: begin
				s = lowest_slot(1'b0, id);
				if (s >= 0) begin
					cap = limit_now + 1;
					if (cap > 255)
						cap = 255;
					if (sess_window[s] != now) begin
						sess_count[s] = '0;
						sess_window[s] = now;
					end
					cnt = sess_count[s];
					cnt = (cnt >= cap) ? cap : cnt + 1;
					sess_count[s] = cnt[7:0];
					v = '{found: 1'b1, allowed: (cnt <= limit_now), slot: s[SLOT_W-1:0]};
				end
			end
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 93)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input logic [1:0] cmd, input logic [15:0] id,
			input logic [31:0] now, input logic typed, input verdict_t want);
		int gap;
		verdict_t v;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 99) >= 55)
			gap = pick_pause();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {now, id};
		do @(posedge clk); while (!s_tready);
		v = apply_command(cmd, id, now);
		pending_verdicts.push_back(typed ? want : v);
		case (cmd)
			CMD_ADD: begin
				n_add++;
				if (!v.found)
					n_full++;
			end
			CMD_REMOVE: n_remove++;
			CMD_CHECK: begin
				n_check++;
				if (v.found && !v.allowed)
					n_over++;
			end
			default: n_unused++;
		endcase
		@(negedge clk);
	endtask

	// only while idle: drop valid, drain every result, then write
	task automatic set_msg_limit(input logic [7:0] value);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		msg_limit_we <= 1'b1;
		msg_limit_wdata <= value;
		@(negedge clk);
		msg_limit_we <= 1'b0;
		limit_now = value;
	endtask

	task automatic cmd_row(input logic [1:0] cmd, input logic [15:0] id, input logic [31:0] now,
			input logic typed, input logic f, input logic a, input logic [SLOT_W-1:0] s);
		stim_row_t r;
		r = '0;
		r.cmd = cmd;
		r.id = id;
		r.now = now;
		r.typed = typed;
		r.want = '{found: f, allowed: a, slot: s};
		directed_rows.push_back(r);
	endtask

	task automatic limit_row(input logic [7:0] value);
		stim_row_t r;
		r = '0;
		r.limit_row = 1'b1;
		r.limit = value;
		directed_rows.push_back(r);
	endtask

	task automatic random_item(input int add_pct, output logic [1:0] cmd,
			output logic [15:0] id, output logic [31:0] now);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			cmd = CMD_ADD;
		else if (r < add_pct + 15)
			cmd = CMD_REMOVE;
		else if (r < 96)
			cmd = CMD_CHECK;
		else
			cmd = CMD_UNUSED;
		// checks come in bursts on one session so small limits get crossed
		if (cmd == CMD_CHECK && $urandom_range(0, 1) == 1)
			id = last_id;
		else if ($urandom_range(0, 19) == 0)
			id = 16'($urandom);
		else
			id = id_pool[$urandom_range(0, 11)];
		last_id = id;
		r = $urandom_range(0, 99);
		if (r < 8)
			clock_sec = clock_sec + $urandom_range(1, 2);
		else if (r < 10)
			clock_sec = $urandom;
		now = clock_sec;
	endtask

	// receiver backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 99) < 25)
					stall_left = pick_pause();
			end
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with nothing pending, tdata", m_tdata, 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[0] !== want.found)
					report_mismatch("found", m_tdata[0], want.found);
				if (m_tdata[1] !== want.allowed)
					report_mismatch("allowed", m_tdata[1], want.allowed);
				if (m_tdata[6:2] !== want.slot)
					report_mismatch("slot_index", m_tdata[6:2], want.slot);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [7:0]  phase_limit [7];
		logic [1:0]  cmd;
		logic [15:0] id;
		logic [31:0] now;
		int          i;
		int          p;
		int          k;
		stim_row_t   row;

		limit_now = MSG_LIMIT_RESET;
		for (i = 0; i < SLOTS; i++) begin
			sess_valid[i] = 1'b0;
			sess_conn[i] = '0;
			sess_count[i] = '0;
			sess_window[i] = '0;
		end
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (i = 2; i < 12; i++)
			id_pool[i] = 16'($urandom);
		last_id = id_pool[0];
		clock_sec = $urandom;

		// empty table, then extremes, duplicates and limit corner values
		cmd_row(CMD_CHECK,  16'h1234, 32'd0,        1, 0, 0, 0);
		cmd_row(CMD_REMOVE, 16'hFFFF, 32'd0,        1, 0, 0, 0);
		cmd_row(CMD_UNUSED, 16'hABCD, 32'hFFFFFFFF, 1, 0, 0, 0);
		cmd_row(CMD_ADD,    16'h0000, 32'd0,        1, 1, 1, 0);
		cmd_row(CMD_ADD,    16'hFFFF, 32'hFFFFFFFF, 1, 1, 1, 1);
		cmd_row(CMD_ADD,    16'hFFFF, 32'd5,        1, 1, 1, 2);
		cmd_row(CMD_CHECK,  16'h5555, 32'd0,        1, 0, 0, 0);
		limit_row(8'd1);
		cmd_row(CMD_CHECK,  16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
		cmd_row(CMD_CHECK,  16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
		cmd_row(CMD_CHECK,  16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
		cmd_row(CMD_CHECK,  16'hFFFF, 32'd0,        0, 0, 0, 0);
		cmd_row(CMD_REMOVE, 16'hFFFF, 32'd0,        1, 1, 1, 1);
		cmd_row(CMD_CHECK,  16'hFFFF, 32'd5,        0, 0, 0, 0);
		cmd_row(CMD_ADD,    16'hAAAA, 32'd7,        1, 1, 1, 1);
		limit_row(8'd0);
		cmd_row(CMD_CHECK,  16'h0000, 32'd0,        1, 1, 0, 0);
		limit_row(8'd255);
		cmd_row(CMD_CHECK,  16'h0000, 32'd0,        1, 1, 1, 0);
		cmd_row(CMD_CHECK,  16'h0000, 32'd0,        1, 1, 1, 0);
		cmd_row(CMD_CHECK,  16'h0000, 32'd0,        1, 1, 1, 0);
		// count above the new bound gets pulled down
		limit_row(8'd1);
		cmd_row(CMD_CHECK,  16'h0000, 32'd0,        0, 0, 0, 0);
		cmd_row(CMD_REMOVE, 16'h0000, 32'd0,        1, 1, 1, 0);
		cmd_row(CMD_REMOVE, 16'h0000, 32'd0,        1, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.limit_row)
				set_msg_limit(row.limit);
			else
				send_item(row.cmd, row.id, row.now, row.typed, row.want);
		end

		phase_limit[0] = 8'd3;
		phase_limit[1] = 8'd1;
		phase_limit[2] = 8'd254;
		phase_limit[3] = 8'd255;
		phase_limit[4] = 8'd0;
		phase_limit[5] = 8'($urandom_range(2, 253));
		phase_limit[6] = 8'd10;
		for (p = 0; p < 7; p++) begin
			set_msg_limit(phase_limit[p]);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// first phase leans on add so the table fills up
			for (k = 0; k < 75; k++) begin
				random_item((p == 0) ? 60 : 28, cmd, id, now);
				send_item(cmd, id, now, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("summary: %0d commands (%0d add, %0d remove, %0d check, %0d unused), %0d results",
			n_add + n_remove + n_check + n_unused, n_add, n_remove, n_check, n_unused,
			results_seen);
		$display("summary: %0d checks over limit, %0d adds on a full table, limits 0 to 255",
			n_over, n_full);
		if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/strl_pkg.sv
hdl/strl_ctrl.sv
hdl/strl_dp.sv
hdl/session_table_rate_limiter.sv
test/session_table_rate_limiter_tb.sv
